@@ rtl/lscdf_pkg.sv @@
// Shared types and constants for the light sampling CDF table builder.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package lscdf_pkg;

  // Field widths of the light beat and the table entry beat
  localparam int unsigned RADIANCE_W = 24;
  localparam int unsigned AREA_W     = 32;
  localparam int unsigned INDEX_W    = 6;
  localparam int unsigned QUO_W      = 24;
  localparam int unsigned EDGE_W     = QUO_W + 1;

  // Luminance datapath: UQ0.16 coefficients, 40-bit accumulator
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned LUM_ACC_W  = COEF_W + RADIANCE_W;
  localparam int unsigned WEIGHT_W   = RADIANCE_W + AREA_W;
  localparam int unsigned TOTAL_W    = 64;

  localparam logic [COEF_W-1:0] LUM_RED   = 16'd13933;
  localparam logic [COEF_W-1:0] LUM_GREEN = 16'd46871;
  localparam logic [COEF_W-1:0] LUM_BLUE  = 16'd4732;
  localparam logic [LUM_ACC_W-1:0] LUM_ROUND = LUM_ACC_W'(1) << (COEF_W - 1);

  // Edge of a full bin: 1.0 on the 2^24 grid
  localparam logic [EDGE_W-1:0] ONE_EDGE = {1'b1, {QUO_W{1'b0}}};

  // Restoring divider step count, one quotient bit per cycle
  localparam int unsigned DIV_CNT_W = $clog2(QUO_W);

  // Defaults for the top level
  localparam int unsigned MAX_LIGHTS_DEF = 64;
  localparam logic [AREA_W-1:0] DISTANT_AREA_RST = 32'h0001_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LUM,
    S_MUL,
    S_STORE,
    S_RD,
    S_ACC,
    S_DIV,
    S_CEIL,
    S_PUT
  } lscdf_state_e;

endpackage

@@ rtl/lscdf_light_if.sv @@
// Valid/ready channel that carries one light record per beat.
// Depends on lscdf_pkg for the field widths.
`timescale 1ns / 1ps

interface lscdf_light_if;
  import lscdf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  light_is_distant;
  logic [RADIANCE_W-1:0] radiance_red;
  logic [RADIANCE_W-1:0] radiance_green;
  logic [RADIANCE_W-1:0] radiance_blue;
  logic [AREA_W-1:0]     light_area;
  logic                  last_light;

  modport source (
    output valid, light_is_distant, radiance_red, radiance_green, radiance_blue,
           light_area, last_light,
    input  ready
  );

  modport sink (
    input  valid, light_is_distant, radiance_red, radiance_green, radiance_blue,
           light_area, last_light,
    output ready
  );

endinterface

@@ rtl/lscdf_entry_if.sv @@
// Valid/ready channel that carries one CDF table entry per beat.
// Depends on lscdf_pkg for the field widths.
`timescale 1ns / 1ps

interface lscdf_entry_if;
  import lscdf_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] light_index;
  logic [EDGE_W-1:0]  cdf_edge;
  logic [EDGE_W-1:0]  bin_probability;
  logic               table_usable;
  logic               last_entry;

  modport source (
    output valid, light_index, cdf_edge, bin_probability, table_usable, last_entry,
    input  ready
  );

  modport sink (
    input  valid, light_index, cdf_edge, bin_probability, table_usable, last_entry,
    output ready
  );

endinterface

@@ rtl/light_sampling_cdf_builder_unit.sv @@
// Top level of the light sampling CDF table builder: weight store, loader and
// table emitter. Depends on lscdf_pkg, lscdf_light_if and lscdf_entry_if.
`timescale 1ns / 1ps

// Lights arrive one per beat. Each light passes through S_LUM (luminance
// accumulated one color channel at a time on one 16x24 multiplier), S_MUL
// (the 24x32 luminance-times-area product) and S_STORE (weight memory write
// and add to the total) before the next light can be taken. A light that
// carries last_light starts the table; the input stays closed until the
// final entry has been placed in the output register. Each entry reads its
// weight from the single-port memory, accumulates it, and, unless it is the
// last entry, the total is zero or the running sum has reached the total,
// runs a restoring divider that yields one quotient bit per cycle; any entry
// also waits while the sink holds ready low. Lights beyond MAX_LIGHTS in one
// set are dropped. The weight memory needs no clearing after reset; only
// entries written in the current set are read.
module light_sampling_cdf_builder_unit #(
  parameter int unsigned MAX_LIGHTS = lscdf_pkg::MAX_LIGHTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lscdf_pkg::AREA_W-1:0]  cfg_wdata_i,
  lscdf_light_if.sink                   light_i,
  lscdf_entry_if.source                 entry_o
);
  import lscdf_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_LIGHTS);
  localparam int unsigned CNT_W = $clog2(MAX_LIGHTS + 1);

  // Control and datapath registers
  lscdf_state_e          state_q, state_d;
  logic [AREA_W-1:0]     distant_area_q;
  logic [RADIANCE_W-1:0] red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [AREA_W-1:0]     area_q, area_d;
  logic                  last_q, last_d;
  logic [1:0]            step_q, step_d;
  logic [LUM_ACC_W-1:0]  lum_acc_q, lum_acc_d;
  logic [WEIGHT_W-1:0]   w_q, w_d;
  logic [TOTAL_W-1:0]    total_q, total_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic [TOTAL_W-1:0]    run_q, run_d;
  logic [TOTAL_W-1:0]    rem_q, rem_d;
  logic [QUO_W-1:0]      quo_q, quo_d;
  logic [DIV_CNT_W-1:0]  div_cnt_q, div_cnt_d;
  logic [EDGE_W-1:0]     edge_q, edge_d;
  logic [EDGE_W-1:0]     prev_q, prev_d;
  logic                  usable_q, usable_d;

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic [INDEX_W-1:0]    out_idx_q, out_idx_d;
  logic [EDGE_W-1:0]     out_edge_q, out_edge_d;
  logic [EDGE_W-1:0]     out_prob_q, out_prob_d;
  logic                  out_usable_q, out_usable_d;
  logic                  out_last_q, out_last_d;

  // Weight memory, one write or one read port used per cycle
  logic [WEIGHT_W-1:0]   wmem [MAX_LIGHTS];
  logic [WEIGHT_W-1:0]   rdata_q;
  logic                  mem_we;

  // Combinational helpers
  logic [COEF_W-1:0]     coef_sel;
  logic [RADIANCE_W-1:0] color_sel;
  logic [LUM_ACC_W-1:0]  lum_prod;
  logic [RADIANCE_W-1:0] lum;
  logic [TOTAL_W-1:0]    run_sum;
  logic [TOTAL_W-1:0]    rem_sh;
  logic                  rd_last;
  logic                  store_full;
  logic                  out_free;

  // Select the color channel and coefficient for this accumulation step
  always_comb begin
    case (step_q)
      2'd0: begin
        coef_sel  = LUM_RED;
        color_sel = red_q;
      end
      2'd1: begin
        coef_sel  = LUM_GREEN;
        color_sel = green_q;
      end
      default: begin
        coef_sel  = LUM_BLUE;
        color_sel = blue_q;
      end
    endcase
  end

  assign lum_prod   = LUM_ACC_W'(coef_sel) * LUM_ACC_W'(color_sel);
  assign lum        = lum_acc_q[COEF_W +: RADIANCE_W];
  assign run_sum    = run_q + TOTAL_W'(rdata_q);
  assign rem_sh     = {rem_q[TOTAL_W-2:0], 1'b0};
  assign rd_last    = (CNT_W'(rd_idx_q) + CNT_W'(1)) == cnt_q;
  assign store_full = cnt_q >= CNT_W'(MAX_LIGHTS);
  assign out_free   = !out_valid_q || entry_o.ready;

  assign light_i.ready = (state_q == S_IDLE);

  // Next state and datapath
  always_comb begin
    state_d      = state_q;
    red_d        = red_q;
    green_d      = green_q;
    blue_d       = blue_q;
    area_d       = area_q;
    last_d       = last_q;
    step_d       = step_q;
    lum_acc_d    = lum_acc_q;
    w_d          = w_q;
    total_d      = total_q;
    cnt_d        = cnt_q;
    rd_idx_d     = rd_idx_q;
    run_d        = run_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    div_cnt_d    = div_cnt_q;
    edge_d       = edge_q;
    prev_d       = prev_q;
    usable_d     = usable_q;
    out_valid_d  = out_valid_q && !entry_o.ready;
    out_idx_d    = out_idx_q;
    out_edge_d   = out_edge_q;
    out_prob_d   = out_prob_q;
    out_usable_d = out_usable_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;

    case (state_q)
      // Take a light beat; pick the area now
      S_IDLE: begin
        if (light_i.valid) begin
          red_d     = light_i.radiance_red;
          green_d   = light_i.radiance_green;
          blue_d    = light_i.radiance_blue;
          area_d    = light_i.light_is_distant ? distant_area_q : light_i.light_area;
          last_d    = light_i.last_light;
          step_d    = 2'd0;
          lum_acc_d = LUM_ROUND;
          state_d   = S_LUM;
        end
      end

      // Accumulate one weighted color channel per cycle
      S_LUM: begin
        lum_acc_d = lum_acc_q + lum_prod;
        step_d    = step_q + 2'd1;
        if (step_q == 2'd2) begin
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        w_d     = WEIGHT_W'(lum) * WEIGHT_W'(area_q);
        state_d = S_STORE;
      end

      // Store the weight unless the set is full; close the set on last_light
      S_STORE: begin
        if (!store_full) begin
          mem_we  = 1'b1;
          total_d = total_q + TOTAL_W'(w_q);
          cnt_d   = cnt_q + CNT_W'(1);
        end
        if (last_q) begin
          rd_idx_d = '0;
          run_d    = '0;
          prev_d   = '0;
          state_d  = S_RD;
        end else begin
          state_d = S_IDLE;
        end
      end

      // Issue the weight read for this entry
      S_RD: begin
        usable_d = (total_q != '0);
        state_d  = S_ACC;
      end

      // Add the weight; start the divide only where an edge must be computed
      S_ACC: begin
        run_d = run_sum;
        if (!usable_q || rd_last || run_sum >= total_q) begin
          edge_d  = ONE_EDGE;
          state_d = S_PUT;
        end else begin
          rem_d     = run_sum;
          quo_d     = '0;
          div_cnt_d = '0;
          state_d   = S_DIV;
        end
      end

      // One restoring quotient bit per cycle
      S_DIV: begin
        if (rem_sh >= total_q) begin
          rem_d = rem_sh - total_q;
          quo_d = {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[QUO_W-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
        if (div_cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
          state_d = S_CEIL;
        end
      end

      // Round the quotient up when a remainder is left
      S_CEIL: begin
        edge_d  = EDGE_W'(quo_q) + EDGE_W'(rem_q != '0);
        state_d = S_PUT;
      end

      // Hand the entry to the output register once it is free
      S_PUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_idx_d    = INDEX_W'(rd_idx_q);
          out_usable_d = usable_q;
          out_last_d   = rd_last;
          if (usable_q) begin
            out_edge_d = edge_q;
            out_prob_d = (edge_q >= prev_q) ? (edge_q - prev_q) : '0;
            if (edge_q > prev_q) begin
              prev_d = edge_q;
            end
          end else begin
            out_edge_d = ONE_EDGE;
            out_prob_d = '0;
          end
          if (rd_last) begin
            total_d = '0;
            cnt_d   = '0;
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + IDX_W'(1);
            state_d  = S_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state and the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      distant_area_q <= DISTANT_AREA_RST;
      total_q        <= '0;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        distant_area_q <= cfg_wdata_i;
      end
    end
  end

  // Advance payload registers
  always_ff @(posedge clk_i) begin
    red_q        <= red_d;
    green_q      <= green_d;
    blue_q       <= blue_d;
    area_q       <= area_d;
    last_q       <= last_d;
    step_q       <= step_d;
    lum_acc_q    <= lum_acc_d;
    w_q          <= w_d;
    rd_idx_q     <= rd_idx_d;
    run_q        <= run_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    div_cnt_q    <= div_cnt_d;
    edge_q       <= edge_d;
    prev_q       <= prev_d;
    usable_q     <= usable_d;
    out_idx_q    <= out_idx_d;
    out_edge_q   <= out_edge_d;
    out_prob_q   <= out_prob_d;
    out_usable_q <= out_usable_d;
    out_last_q   <= out_last_d;
  end

  // Weight memory: writes happen only while loading; rdata_q is loaded whenever no write is made
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wmem[cnt_q[IDX_W-1:0]] <= w_q;
    end else begin
      rdata_q <= wmem[rd_idx_q];
    end
  end

  // Drive the entry channel
  assign entry_o.valid           = out_valid_q;
  assign entry_o.light_index     = out_idx_q;
  assign entry_o.cdf_edge        = out_edge_q;
  assign entry_o.bin_probability = out_prob_q;
  assign entry_o.table_usable    = out_usable_q;
  assign entry_o.last_entry      = out_last_q;

endmodule

@@ rtl/lscdf_checker.sv @@
// Port-level checks for the light sampling CDF table builder, bound to the top.
// Depends on lscdf_pkg and light_sampling_cdf_builder_unit.
`timescale 1ns / 1ps

module lscdf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [lscdf_pkg::INDEX_W-1:0] out_idx_i,
  input logic [lscdf_pkg::EDGE_W-1:0]  out_edge_i,
  input logic [lscdf_pkg::EDGE_W-1:0]  out_prob_i,
  input logic                         out_usable_i,
  input logic                         out_last_i
);
  import lscdf_pkg::*;

  // A stalled entry beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_edge_i) &&
      $stable(out_idx_i) && $stable(out_prob_i))
    else $error("entry beat changed while stalled");

  // Each accepted light keeps the input closed on the next cycle
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input open right after a light beat");

  // The final entry always closes the table at 1.0
  a_last_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> out_edge_i == ONE_EDGE)
    else $error("last entry edge is not one");

  // An unusable table carries full edges and empty bins
  a_unusable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_usable_i |-> out_edge_i == ONE_EDGE && out_prob_i == '0)
    else $error("unusable entry has wrong edge or width");

  // A bin never extends below zero
  a_prob_le_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_prob_i <= out_edge_i)
    else $error("bin width exceeds its edge");

endmodule

bind light_sampling_cdf_builder_unit lscdf_checker u_lscdf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (light_i.valid),
  .in_ready_i   (light_i.ready),
  .out_valid_i  (entry_o.valid),
  .out_ready_i  (entry_o.ready),
  .out_idx_i    (entry_o.light_index),
  .out_edge_i   (entry_o.cdf_edge),
  .out_prob_i   (entry_o.bin_probability),
  .out_usable_i (entry_o.table_usable),
  .out_last_i   (entry_o.last_entry)
);

@@ sim/tb_light_sampling_cdf_builder_unit.sv @@
// Testbench for light_sampling_cdf_builder_unit: streams light records and
// checks every CDF table entry against a local predictor of the weight table or a typed entry.
// Depends on lscdf_pkg, lscdf_light_if, lscdf_entry_if and the RTL top level.
`timescale 1ns / 1ps

module tb_light_sampling_cdf_builder_unit;
  import lscdf_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 500;
  localparam int unsigned IDLE_GAP    = 40;
  localparam int unsigned SET_ITEMS   = 60;

  // Rec.709 luminance weights, UQ0.16
  localparam logic [47:0] W_RED   = 48'd13933;
  localparam logic [47:0] W_GREEN = 48'd46871;
  localparam logic [47:0] W_BLUE  = 48'd4732;
  localparam logic [24:0] FULL_EDGE = 25'h100_0000;

  typedef struct packed {
    logic                  distant;
    logic [RADIANCE_W-1:0] red;
    logic [RADIANCE_W-1:0] green;
    logic [RADIANCE_W-1:0] blue;
    logic [AREA_W-1:0]     area;
    logic                  last;
  } light_t;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [EDGE_W-1:0]  cdf_edge;
    logic [EDGE_W-1:0]  bin_prob;
    logic               usable;
    logic               last;
  } entry_t;

  typedef struct packed {
    light_t lt;
    logic   typed;
    entry_t want;
  } drow_t;

  localparam entry_t NO_ENTRY  = '0;
  localparam entry_t FULL_BIN  = '{6'd0, FULL_EDGE, FULL_EDGE, 1'b1, 1'b1};
  localparam entry_t EMPTY_BIN = '{6'd0, FULL_EDGE, 25'd0, 1'b0, 1'b1};

  // Single-light sets carry a typed entry; longer sets go through the predictor
  localparam drow_t DIRECTED_ROWS [20] = '{
    '{'{1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1}, 1'b1, FULL_BIN},
    '{'{1'b0, 24'h000000, 24'h000000, 24'h000000, 32'hFFFFFFFF, 1'b1}, 1'b1, EMPTY_BIN},
    '{'{1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'h00000000, 1'b1}, 1'b1, FULL_BIN},
    '{'{1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'h00000000, 1'b1}, 1'b1, EMPTY_BIN},
    '{'{1'b0, 24'h000001, 24'h000000, 24'h000000, 32'hFFFFFFFF, 1'b1}, 1'b1, EMPTY_BIN},
    '{'{1'b0, 24'hFFFFFF, 24'h000000, 24'h000000, 32'h00010000, 1'b0}, 1'b0, NO_ENTRY},
    '{'{1'b0, 24'h000000, 24'hFFFFFF, 24'h000000, 32'h00010000, 1'b0}, 1'b0, NO_ENTRY},
    '{'{1'b0, 24'h000000, 24'h000000, 24'hFFFFFF, 32'h00010000, 1'b0}, 1'b0, NO_ENTRY},
    '{'{1'b0, 24'h000000, 24'h000000, 24'h000000, 32'hFFFFFFFF, 1'b0}, 1'b0, NO_ENTRY},
    '{'{1'b0, 24'h000000, 24'h000001, 24'h000000, 32'h00000001, 1'b1}, 1'b0, NO_ENTRY},
    '{'{1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0}, 1'b0, NO_ENTRY},
    '{'{1'b0, 24'h000000, 24'h000001, 24'h000000, 32'h00000001, 1'b0}, 1'b0, NO_ENTRY},
    '{'{1'b0, 24'h000000, 24'h000001, 24'h000000, 32'h00000001, 1'b1}, 1'b0, NO_ENTRY},
    '{'{1'b1, 24'h800000, 24'h000000, 24'h000000, 32'h00000000, 1'b0}, 1'b0, NO_ENTRY},
    '{'{1'b1, 24'h000000, 24'h000000, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0}, 1'b0, NO_ENTRY},
    '{'{1'b0, 24'h000000, 24'h800000, 24'h000000, 32'h00000001, 1'b1}, 1'b0, NO_ENTRY},
    '{'{1'b0, 24'h000000, 24'h000000, 24'h000000, 32'h00000005, 1'b0}, 1'b0, NO_ENTRY},
    '{'{1'b1, 24'h000000, 24'h000000, 24'h000000, 32'h00000000, 1'b1}, 1'b0, NO_ENTRY},
    '{'{1'b0, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 32'hAAAA5555, 1'b0}, 1'b0, NO_ENTRY},
    '{'{1'b0, 24'h555555, 24'hAAAAAA, 24'h555555, 32'h5555AAAA, 1'b1}, 1'b0, NO_ENTRY}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [AREA_W-1:0] cfg_wdata_i;

  lscdf_light_if light_bus ();
  lscdf_entry_if entry_bus ();

  light_sampling_cdf_builder_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .light_i     (light_bus),
    .entry_o     (entry_bus)
  );

  // Predictor state: a private copy of the register and the weight table
  logic [AREA_W-1:0] distant_area_copy;
  logic [55:0]       weight_copy [TABLE_DEPTH];
  logic [63:0]       total_copy;
  int unsigned       light_tally;

  entry_t      fresh_entries [$];
  entry_t      entries_due [$];
  entry_t      oldest_due;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned stall_ticket;
  int unsigned stall_seen;
  int unsigned hold_left;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // ceil(cum * 2^24 / tot), capped at one full bin
  function automatic logic [24:0] cdf_edge_of(logic [63:0] cum, logic [63:0] tot);
    logic [127:0] q;
    if (cum >= tot) return FULL_EDGE;
    q = (({64'd0, cum} << 24) + {64'd0, tot} - 128'd1) / {64'd0, tot};
    return (q > {103'd0, FULL_EDGE}) ? FULL_EDGE : q[24:0];
  endfunction

  // Store the light's weight; on the closing light build the whole table
  task automatic absorb_light(input light_t lt);
    logic [47:0] acc;
    logic [23:0] lum;
    logic [31:0] area;
    logic [55:0] w;
    logic [63:0] cum;
    logic [24:0] prev;
    logic [24:0] e;
    logic [24:0] prob;
    logic        use_it;
    area = lt.distant ? distant_area_copy : lt.area;
    acc  = W_RED * 48'(lt.red) + W_GREEN * 48'(lt.green) + W_BLUE * 48'(lt.blue) + 48'd32768;
    lum  = acc[39:16];
    // drop lights once the table is full
    if (light_tally < TABLE_DEPTH) begin
      w = 56'(lum) * 56'(area);
      weight_copy[light_tally] = w;
      total_copy += 64'(w);
      light_tally++;
    end
    if (lt.last) begin
      use_it = (light_tally > 0) && (total_copy != 0);
      cum  = '0;
      prev = '0;
      for (int unsigned i = 0; i < light_tally; i++) begin
        if (use_it) begin
          cum += 64'(weight_copy[i]);
          e = (i + 1 == light_tally) ? FULL_EDGE : cdf_edge_of(cum, total_copy);
          prob = (e >= prev) ? e - prev : 25'd0;
          if (e > prev) prev = e;
        end else begin
          e    = FULL_EDGE;
          prob = 25'd0;
        end
        fresh_entries.push_back('{6'(i), e, prob, use_it, (i + 1 == light_tally)});
      end
      total_copy  = '0;
      light_tally = 0;
    end
  endtask

  // Offer one light beat, idle at random first, and predict on acceptance
  task automatic offer_light(input light_t lt, input logic typed, input entry_t typed_entry);
    while ($urandom_range(99) < src_idle_pct) begin
      light_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    light_bus.valid            <= 1'b1;
    light_bus.light_is_distant <= lt.distant;
    light_bus.radiance_red     <= lt.red;
    light_bus.radiance_green   <= lt.green;
    light_bus.radiance_blue    <= lt.blue;
    light_bus.light_area       <= lt.area;
    light_bus.last_light       <= lt.last;
    @(posedge clk_i);
    while (!light_bus.ready) @(posedge clk_i);
    absorb_light(lt);
    if (typed) begin
      fresh_entries.delete();
      entries_due.push_back(typed_entry);
    end else begin
      while (fresh_entries.size() > 0) entries_due.push_back(fresh_entries.pop_front());
    end
  endtask

  // Wait for the table to drain, then let the block settle
  task automatic wait_drained();
    while (entries_due.size() > 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  task automatic write_distant_area(input logic [AREA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    distant_area_copy = value;
  endtask

  function automatic logic [RADIANCE_W-1:0] random_radiance();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return RADIANCE_W'($urandom_range(255));
      default: return RADIANCE_W'($urandom);
    endcase
  endfunction

  function automatic light_t random_light(input logic dark);
    light_t lt;
    lt.distant = ($urandom_range(3) == 0);
    lt.red     = dark ? '0 : random_radiance();
    lt.green   = dark ? '0 : random_radiance();
    lt.blue    = dark ? '0 : random_radiance();
    case ($urandom_range(7))
      0: lt.area = '0;
      1: lt.area = '1;
      2, 3: lt.area = AREA_W'($urandom_range(32'h3FFFF));
      default: lt.area = AREA_W'($urandom);
    endcase
    lt.last = 1'b0;
    return lt;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Sink side: random ready, with one long hold-off on request
  initial begin
    entry_bus.ready = 1'b0;
    stall_seen      = 0;
    hold_left       = 0;
    forever begin
      @(posedge clk_i);
      if (stall_ticket != stall_seen) begin
        stall_seen = stall_ticket;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        entry_bus.ready <= 1'b0;
      end else begin
        entry_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Compare each accepted entry beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && entry_bus.valid && entry_bus.ready) begin
      if (entries_due.size() == 0) begin
        $error("unexpected entry: light_index %0d", entry_bus.light_index);
        fail_count++;
      end else begin
        oldest_due = entries_due.pop_front();
        check_field("light_index", 32'(oldest_due.idx), 32'(entry_bus.light_index));
        check_field("cdf_edge", 32'(oldest_due.cdf_edge), 32'(entry_bus.cdf_edge));
        check_field("bin_probability", 32'(oldest_due.bin_prob),
                    32'(entry_bus.bin_probability));
        check_field("table_usable", 32'(oldest_due.usable), 32'(entry_bus.table_usable));
        check_field("last_entry", 32'(oldest_due.last), 32'(entry_bus.last_entry));
      end
    end
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_light_sampling_cdf_builder_unit NOT OK");
    $finish;
  end

  // Main stimulus: directed table, then three random phases
  initial begin
    light_t      lt;
    int unsigned sent;
    int unsigned set_len;
    logic        dark;
    rst_ni                     = 1'b0;
    cfg_we_i                   = 1'b0;
    cfg_wdata_i                = '0;
    light_bus.valid            = 1'b0;
    light_bus.light_is_distant = 1'b0;
    light_bus.radiance_red     = '0;
    light_bus.radiance_green   = '0;
    light_bus.radiance_blue    = '0;
    light_bus.light_area       = '0;
    light_bus.last_light       = 1'b0;
    distant_area_copy          = 32'h0001_0000;
    total_copy                 = '0;
    light_tally                = 0;
    fail_count                 = 0;
    src_idle_pct               = 0;
    sink_idle_pct              = 0;
    stall_ticket               = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table at the reset value of the register
    src_idle_pct = 20;
    sink_idle_pct <= 20;
    foreach (DIRECTED_ROWS[i]) offer_light(DIRECTED_ROWS[i].lt, DIRECTED_ROWS[i].typed,
                                           DIRECTED_ROWS[i].want);
    light_bus.valid <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          src_idle_pct = 37;
          sink_idle_pct <= 66;
          write_distant_area(32'h0000_0000);
          stall_ticket <= stall_ticket + 1;
        end
        1: begin
          src_idle_pct = 66;
          sink_idle_pct <= 37;
          write_distant_area(32'hFFFF_FFFF);
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct <= 0;
          write_distant_area(AREA_W'($urandom));
        end
      endcase
      sent = 0;
      while (sent < SET_ITEMS) begin
        set_len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(5, 1);
        dark    = ($urandom_range(15) == 0);
        for (int unsigned k = 0; k < set_len; k++) begin
          lt      = random_light(dark);
          lt.last = (k + 1 == set_len);
          offer_light(lt, 1'b0, NO_ENTRY);
          sent++;
        end
      end
      // Overflow the table: the closing light is itself dropped
      if (phase == 2) begin
        for (int unsigned k = 0; k < TABLE_DEPTH + 6; k++) begin
          lt      = random_light(1'b0);
          lt.last = (k == TABLE_DEPTH + 5);
          offer_light(lt, 1'b0, NO_ENTRY);
        end
      end
      light_bus.valid <= 1'b0;
    end

    wait_drained();
    repeat (64) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_light_sampling_cdf_builder_unit OK");
    end else begin
      $display("tb_light_sampling_cdf_builder_unit NOT OK");
    end
    $finish;
  end

endmodule
